FILE: design/ssr_pkg.sv
// Shared constants and types of the streaming find-and-replace block.
package ssr_pkg;

  localparam int WIN_DEPTH       = 16;
  localparam int MAX_PATTERN     = 16;
  localparam int MAX_REPLACEMENT = 16;
  localparam int IDX_W           = $clog2(WIN_DEPTH);
  localparam int CNT_W           = IDX_W + 1;
  localparam int PAT_LIM         = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;
  localparam int REP_LIM         = (MAX_REPLACEMENT < WIN_DEPTH) ? MAX_REPLACEMENT : WIN_DEPTH;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_HI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN = 3'd5;

  typedef logic [WIN_DEPTH-1:0][7:0] byte_vec_t;

  typedef enum logic [1:0] {
    CMD_WINDOW,
    CMD_REPL,
    CMD_MARKER
  } cmd_kind_t;

  // One step's worth of output work, handed from front to back.
  typedef struct packed {
    cmd_kind_t        kind;
    logic [CNT_W-1:0] count;
    logic             last;
    byte_vec_t        snap;
  } cmd_t;

endpackage

FILE: design/ssr_front.sv
// Front end: window of pending bytes, match test and command generation.
module ssr_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [7:0]               in_text_byte,
  input  logic                     in_end_of_text,
  input  ssr_pkg::byte_vec_t       pattern,
  input  logic [ssr_pkg::CNT_W-1:0] plen,
  input  logic [ssr_pkg::CNT_W-1:0] rlen,
  output logic                     push,
  output ssr_pkg::cmd_t            cmd
);
  import ssr_pkg::*;

  byte_vec_t        win_r;
  logic [CNT_W-1:0] fill_r;

  byte_vec_t        w;
  byte_vec_t        win_nxt;
  logic [CNT_W-1:0] fill_nxt;
  logic [CNT_W-1:0] nf;
  logic [CNT_W-1:0] emit;
  logic [CNT_W-1:0] keep;
  logic             over;
  logic             full;
  logic             match;
  logic             present;
  logic [CNT_W:0]   src;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w[i] = (fill_r[IDX_W-1:0] == IDX_W'(i)) ? in_text_byte : win_r[i];
    end
    nf   = fill_r + CNT_W'(1);
    over = nf > plen;
    full = nf == plen;
    match = full;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((CNT_W'(i) < plen) && (w[i] != pattern[i])) match = 1'b0;
    end

    if (over) begin
      emit = nf - (plen - CNT_W'(1));
      keep = plen - CNT_W'(1);
    end else if (match) begin
      emit = '0;
      keep = '0;
    end else if (full) begin
      emit = CNT_W'(1);
      keep = plen - CNT_W'(1);
    end else begin
      emit = '0;
      keep = nf;
    end
    // flush everything still pending at end of text
    if (in_end_of_text) begin
      emit = emit + keep;
      keep = '0;
    end

    // drop the emitted oldest bytes
    for (int i = 0; i < WIN_DEPTH; i++) begin
      src = (CNT_W+1)'(i) + {1'b0, emit};
      win_nxt[i] = (src < (CNT_W+1)'(WIN_DEPTH)) ? w[src[IDX_W-1:0]] : 8'd0;
    end
    fill_nxt = keep;

    cmd.snap = w;
    cmd.last = in_end_of_text;
    if (match && (rlen != '0)) begin
      cmd.kind  = CMD_REPL;
      cmd.count = rlen;
      present   = 1'b1;
    end else if (!match && (emit != '0)) begin
      cmd.kind  = CMD_WINDOW;
      cmd.count = emit;
      present   = 1'b1;
    end else begin
      cmd.kind  = CMD_MARKER;
      cmd.count = CNT_W'(1);
      present   = in_end_of_text;
    end
  end

  assign push = in_valid && in_ready && present;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_valid && in_ready) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      win_r <= win_nxt;
    end
  end

endmodule

FILE: design/ssr_queue.sv
// Short command queue between front and back.
module ssr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output ssr_pkg::cmd_t head
);
  import ssr_pkg::*;

  cmd_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_cmd;
  end

endmodule

FILE: design/ssr_back.sv
// Back end: expands queued commands into result transactions.
module ssr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ssr_pkg::cmd_t      q_head,
  output logic               q_pop,
  input  ssr_pkg::byte_vec_t replacement,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_has_byte,
  output logic               out_last
);
  import ssr_pkg::*;

  cmd_t             cur_r;
  logic             active_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_has_r;
  logic             out_last_r;

  logic       produce;
  logic       final_el;
  logic [7:0] byte_sel;
  logic       has_sel;

  always_comb begin
    produce  = active_r && (!out_valid_r || out_ready);
    final_el = {1'b0, idx_r} == (cur_r.count - CNT_W'(1));
    q_pop    = q_valid && (!active_r || (produce && final_el));
    case (cur_r.kind)
      CMD_WINDOW: begin
        byte_sel = cur_r.snap[idx_r];
        has_sel  = 1'b1;
      end
      CMD_REPL: begin
        byte_sel = replacement[idx_r];
        has_sel  = 1'b1;
      end
      default: begin
        byte_sel = 8'd0;
        has_sel  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (produce) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (q_pop) begin
        active_r <= 1'b1;
        idx_r    <= '0;
      end else if (produce) begin
        if (final_el) active_r <= 1'b0;
        else idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (produce) begin
      out_byte_r <= byte_sel;
      out_has_r  <= has_sel;
      out_last_r <= cur_r.last && final_el;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = out_has_r;
  assign out_last     = out_last_r;

endmodule

FILE: design/stream_substring_replace_top.sv
// Top level: configuration registers and the front, queue and back ends.
//
// Streaming find-and-replace. Text bytes enter on the in_ channel, one per
// transaction, with in_end_of_text on the final byte. Rewritten bytes leave
// on the out_ channel; out_has_byte is low only on a bare end marker and
// out_last flags the final result of each text.
// The cfg_ channel writes the pattern, replacement and their lengths and is
// always ready; the user must see that it is written only while the block is
// idle, as the block does not enforce it. A result passes the command queue,
// the back end's command register and the output register. Throughput: while
// out_ready is high, one input byte per cycle if each byte yields at most one
// result; the back end emits one result per cycle, one per replacement or flush
// byte, and a four-entry command queue absorbs that before in_ready drops.
// Reset empties the window and the queue and restores the default config
// (pattern length 1, empty replacement).
// When the receiver stalls, the output register holds its result, the
// queue fills, and then in_ready goes low until results drain.
module stream_substring_replace_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_text_byte,
  input  logic                            in_end_of_text,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_has_byte,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);
  import ssr_pkg::*;

  logic [63:0] pat_lo_r;
  logic [63:0] pat_hi_r;
  logic [4:0]  pat_len_r;
  logic [63:0] rep_lo_r;
  logic [63:0] rep_hi_r;
  logic [4:0]  rep_len_r;

  logic [CNT_W-1:0] plen;
  logic [CNT_W-1:0] rlen;
  byte_vec_t        pattern;
  byte_vec_t        replacement;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= 5'd1;
      rep_lo_r  <= '0;
      rep_hi_r  <= '0;
      rep_len_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAT_LO:  pat_lo_r  <= cfg_data;
        CFG_PAT_HI:  pat_hi_r  <= cfg_data;
        CFG_PAT_LEN: pat_len_r <= cfg_data[4:0];
        CFG_REP_LO:  rep_lo_r  <= cfg_data;
        CFG_REP_HI:  rep_hi_r  <= cfg_data;
        CFG_REP_LEN: rep_len_r <= cfg_data[4:0];
        default:     ;
      endcase
    end
  end

  // clamp lengths: empty pattern acts as one byte, both saturate at the window
  always_comb begin
    if (pat_len_r == '0) plen = CNT_W'(1);
    else if ({1'b0, pat_len_r} > 6'(PAT_LIM)) plen = CNT_W'(PAT_LIM);
    else plen = CNT_W'(pat_len_r);
    if ({1'b0, rep_len_r} > 6'(REP_LIM)) rlen = CNT_W'(REP_LIM);
    else rlen = CNT_W'(rep_len_r);
  end

  assign pattern     = {pat_hi_r, pat_lo_r};
  assign replacement = {rep_hi_r, rep_lo_r};
  assign in_ready    = !q_full;

  ssr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .pattern        (pattern),
    .plen           (plen),
    .rlen           (rlen),
    .push           (q_push),
    .cmd            (push_cmd)
  );

  ssr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  ssr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .replacement  (replacement),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

FILE: dv/tb_stream_substring_replace_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming find-and-replace block.
module tb_stream_substring_replace_top;
  import ssr_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int TEXT_TARGET   = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } rewrite_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
    logic [7:0]           text;
    logic                 eot;
    bit                   known;
    rewrite_t             want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_text_byte;
  logic                 in_end_of_text;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_byte;
  logic                 out_has_byte;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  // Shadow copy of the registers and of the pending window.
  logic [63:0] pat_lo_q = '0;
  logic [63:0] pat_hi_q = '0;
  logic [4:0]  pat_len_q = 5'd1;
  logic [63:0] rep_lo_q = '0;
  logic [63:0] rep_hi_q = '0;
  logic [4:0]  rep_len_q = 5'd0;
  logic [7:0]  shadow_win [WIN_DEPTH];
  int          shadow_fill = 0;

  rewrite_t  rewritten_q[$];
  plan_row_t plan_q[$];
  int        errors = 0;
  int        text_items = 0;
  bit        no_idle = 1'b0;
  bit        hold_req = 1'b0;

  stream_substring_replace_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pat_span();
    if (pat_len_q == 5'd0) return 1;
    if (pat_len_q > PAT_LIM) return PAT_LIM;
    return int'(pat_len_q);
  endfunction

  function automatic int rep_span();
    return (rep_len_q > REP_LIM) ? REP_LIM : int'(rep_len_q);
  endfunction

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    rewrite_t r;
    r.data = b;
    r.has  = 1'b1;
    r.last = 1'b0;
    rewritten_q.push_back(r);
  endfunction

  function automatic logic [7:0] pop_window();
    logic [7:0] b;
    b = shadow_win[0];
    for (int i = 0; i < WIN_DEPTH - 1; i++) shadow_win[i] = shadow_win[i + 1];
    shadow_fill--;
    return b;
  endfunction

  // Work out the rewritten bytes that one text byte releases.
  function automatic void rewrite_byte(input logic [7:0] b, input logic eot);
    int           plen;
    int           rlen;
    int           n0;
    logic [127:0] pat;
    logic [127:0] rep;
    logic         hit;
    rewrite_t     r;
    plen = pat_span();
    rlen = rep_span();
    pat  = {pat_hi_q, pat_lo_q};
    rep  = {rep_hi_q, rep_lo_q};
    n0   = rewritten_q.size();
    if (shadow_fill >= WIN_DEPTH) shadow_fill = WIN_DEPTH - 1;
    shadow_win[shadow_fill] = b;
    shadow_fill++;
    if (shadow_fill > plen) begin
      // pattern shrank under a part-filled window: no match test this step
      while (shadow_fill >= plen) queue_byte(pop_window());
    end else if (shadow_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (shadow_win[i] != pat[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rlen; i++) queue_byte(rep[8*i +: 8]);
        shadow_fill = 0;
      end else begin
        queue_byte(pop_window());
      end
    end
    if (eot) begin
      while (shadow_fill > 0) queue_byte(pop_window());
      if (rewritten_q.size() == n0) begin
        r = '0;
        rewritten_q.push_back(r);
      end
      r = rewritten_q.pop_back();
      r.last = 1'b1;
      rewritten_q.push_back(r);
    end
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_text(input logic [7:0] b, input logic e);
    plan_row_t r;
    r = '{default: '0};
    r.text = b;
    r.eot  = e;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_known(input logic [7:0] b, input logic e, input rewrite_t w);
    plan_row_t r;
    r = '{default: '0};
    r.text  = b;
    r.eot   = e;
    r.known = 1'b1;
    r.want  = w;
    plan_q.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot, input int gap,
                           input bit known = 1'b0, input rewrite_t want = '0);
    int n0;
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    n0 = rewritten_q.size();
    rewrite_byte(b, eot);
    if (known) begin
      while (rewritten_q.size() > n0) void'(rewritten_q.pop_back());
      rewritten_q.push_back(want);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PAT_LO:  pat_lo_q = d;
      CFG_PAT_HI:  pat_hi_q = d;
      CFG_PAT_LEN: pat_len_q = d[4:0];
      CFG_REP_LO:  rep_lo_q = d;
      CFG_REP_HI:  rep_hi_q = d;
      CFG_REP_LEN: rep_len_q = d[4:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every pending result, then let the pipe empty.
  task automatic drain(input int extra);
    @(negedge clk) in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic pick_setting();
    int sel;
    if ($urandom_range(0, 4) != 0) write_reg(CFG_PAT_LO, {$urandom, $urandom});
    if ($urandom_range(0, 4) != 0) write_reg(CFG_PAT_HI, {$urandom, $urandom});
    sel = $urandom_range(0, 19);
    if (sel < 13)      write_reg(CFG_PAT_LEN, 64'($urandom_range(1, 4)));
    else if (sel < 16) write_reg(CFG_PAT_LEN, 64'($urandom_range(5, 16)));
    else if (sel < 18) write_reg(CFG_PAT_LEN, 64'($urandom_range(17, 31)));
    else if (sel < 19) write_reg(CFG_PAT_LEN, 64'd0);
    if ($urandom_range(0, 4) != 0) write_reg(CFG_REP_LO, {$urandom, $urandom});
    if ($urandom_range(0, 4) != 0) write_reg(CFG_REP_HI, {$urandom, $urandom});
    sel = $urandom_range(0, 9);
    if (sel < 7)      write_reg(CFG_REP_LEN, 64'($urandom_range(0, 6)));
    else if (sel < 9) write_reg(CFG_REP_LEN, 64'($urandom_range(7, 16)));
    else              write_reg(CFG_REP_LEN, 64'($urandom_range(17, 31)));
  endtask

  // Mostly pattern copies and pattern bytes so matches happen; some broken copies and noise.
  task automatic send_text(input bit close);
    logic [7:0]   txt[$];
    logic [127:0] pat;
    int           plen;
    int           bad;
    int           pick;
    pat  = {pat_hi_q, pat_lo_q};
    plen = pat_span();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plen - 1) : -1;
          for (int i = 0; i < plen; i++)
            txt.push_back((i == bad) ? pat[8*i +: 8] ^ (8'h01 << $urandom_range(0, 7))
                                     : pat[8*i +: 8]);
        end
        4, 5, 6: begin
          pick = $urandom_range(0, plen - 1);
          txt.push_back(pat[8*pick +: 8]);
        end
        default: txt.push_back(8'($urandom));
      endcase
    end
    foreach (txt[i]) begin
      send_byte(txt[i], close && (i == txt.size() - 1), draw_gap());
      text_items++;
      if ($urandom_range(0, 15) == 0) drain(0);
    end
  endtask

  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk) out_ready <= 1'b0;
      end
      gap = draw_gap();
      repeat (gap) @(negedge clk) out_ready <= 1'b0;
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : out_check
    rewrite_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rewritten_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: out_byte %02h has_byte %0b last %0b",
                 $time, out_byte, out_has_byte, out_last);
      end else begin
        want = rewritten_q.pop_front();
        if (out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
        end
        if (out_has_byte !== want.has) begin
          errors++;
          $display("%0t: has_byte expected %0b actual %0b", $time, want.has, out_has_byte);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = 8'h00;
    in_end_of_text = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_PAT_LO;
    cfg_data       = '0;
    foreach (shadow_win[i]) shadow_win[i] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset defaults: pattern is a single zero byte, replacement empty
    plan_known(8'h41, 1'b0, rewrite_t'{8'h41, 1'b1, 1'b0});
    plan_known(8'h00, 1'b1, rewrite_t'{8'h00, 1'b0, 1'b1});
    plan_known(8'hFF, 1'b1, rewrite_t'{8'hFF, 1'b1, 1'b1});
    plan_cfg(CFG_PAT_LO, 64'h0000_0000_0063_6261);
    plan_cfg(CFG_PAT_LEN, 64'd3);
    plan_cfg(CFG_REP_LO, 64'h5958);
    plan_cfg(CFG_REP_LEN, 64'd2);
    plan_cfg(CFG_SPARE, '1);
    plan_text("z", 1'b0);
    plan_text("a", 1'b0);
    plan_text("b", 1'b0);
    plan_text("c", 1'b0);
    plan_text("a", 1'b0);
    plan_text("b", 1'b0);
    plan_text("c", 1'b1);
    // zero pattern length acts as one; oversize replacement saturates to 16
    plan_cfg(CFG_PAT_LO, '1);
    plan_cfg(CFG_PAT_HI, '1);
    plan_cfg(CFG_PAT_LEN, 64'd0);
    plan_cfg(CFG_REP_LO, 64'h0123_4567_89AB_CDEF);
    plan_cfg(CFG_REP_HI, 64'hFEDC_BA98_7654_3210);
    plan_cfg(CFG_REP_LEN, 64'd31);
    plan_text(8'hFF, 1'b1);
    plan_known(8'h7F, 1'b1, rewrite_t'{8'h7F, 1'b1, 1'b1});
    plan_cfg(CFG_PAT_LEN, 64'd31);
    plan_cfg(CFG_REP_LEN, 64'd0);
    plan_known(8'h00, 1'b1, rewrite_t'{8'h00, 1'b1, 1'b1});
    // shrink the pattern while three bytes are pending
    plan_cfg(CFG_PAT_LO, 64'h6463_6261);
    plan_cfg(CFG_PAT_HI, 64'd0);
    plan_cfg(CFG_PAT_LEN, 64'd4);
    plan_cfg(CFG_REP_LEN, 64'd1);
    plan_text("a", 1'b0);
    plan_text("b", 1'b0);
    plan_text("c", 1'b0);
    plan_cfg(CFG_PAT_LEN, 64'd2);
    plan_text("x", 1'b0);
    plan_text("y", 1'b1);
    plan_text("a", 1'b0);
    plan_text("b", 1'b1);

    foreach (plan_q[k]) begin
      if (plan_q[k].is_cfg) begin
        if (k == 0 || !plan_q[k - 1].is_cfg) drain(SETTLE_CYCLES);
        write_reg(plan_q[k].idx, plan_q[k].data);
      end else begin
        send_byte(plan_q[k].text, plan_q[k].eot, draw_gap(), plan_q[k].known, plan_q[k].want);
        text_items++;
      end
    end

    // Each byte expands to 16 while the receiver holds off: fill up and stall the input.
    drain(SETTLE_CYCLES);
    write_reg(CFG_PAT_LO, 64'h5A);
    write_reg(CFG_PAT_LEN, 64'd1);
    write_reg(CFG_REP_LEN, 64'd16);
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++) send_byte(8'h5A, k == 11, 0);
    text_items += 12;
    drain(0);

    while (text_items < TEXT_TARGET) begin
      drain(SETTLE_CYCLES);
      no_idle = ($urandom_range(0, 3) == 0);
      pick_setting();
      // leave some texts open so the next setting meets a part-filled window
      repeat ($urandom_range(1, 3)) send_text($urandom_range(0, 3) != 0);
    end

    drain(2 * SETTLE_CYCLES);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
